// ----- src/fbit_pkg.sv -----
// Shared types and constants for the filleted box inclusion test.
// No dependencies; used by fbit_cfg and filleted_box_inside_test.
package fbit_pkg;

   localparam int COORD_WIDTH_DEFAULT = 24;
   localparam int HALF_W              = 23;           // register and half extent width
   localparam int SQ_W                = 2 * HALF_W;   // one square
   localparam int SUM_W               = SQ_W + 2;     // sum of three squares
   localparam int CSR_INDEX_W         = 2;

   localparam logic [CSR_INDEX_W-1:0] CSR_HALF_SIZE_X   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_HALF_SIZE_Y   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_HALF_SIZE_Z   = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_FILLET_RADIUS = 2'd3;

   localparam logic [HALF_W-1:0] HALF_SIZE_RESET = 23'd4096;
   localparam logic [HALF_W-1:0] FILLET_RESET    = 23'd0;

   typedef enum logic [2:0] {
      REGION_OUTSIDE = 3'd0,
      REGION_FACE    = 3'd1,
      REGION_Z_EDGE  = 3'd2,
      REGION_Y_EDGE  = 3'd3,
      REGION_X_EDGE  = 3'd4,
      REGION_CORNER  = 3'd5
   } region_type;

   // Registered configuration plus values derived from it.
   typedef struct packed {
      logic [HALF_W-1:0] rx;
      logic [HALF_W-1:0] ry;
      logic [HALF_W-1:0] rz;
      logic [HALF_W-1:0] sx;   // half extent minus fillet radius
      logic [HALF_W-1:0] sy;
      logic [HALF_W-1:0] sz;
      logic [SQ_W-1:0]   f2;   // squared fillet radius
      logic              err;  // fillet radius exceeds a half extent
   } cfg_derived_type;

endpackage

// ----- src/fbit_cfg.sv -----
// Configuration registers and derived constants for the filleted box test.
// Depends on fbit_pkg.
module fbit_cfg (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_wr_en,
   input  logic [fbit_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [fbit_pkg::HALF_W-1:0]        csr_wdata,
   output fbit_pkg::cfg_derived_type          cfg
);

   logic [fbit_pkg::HALF_W-1:0] half_x_ff, half_y_ff, half_z_ff, fillet_ff;
   fbit_pkg::cfg_derived_type   cfg_ff, cfg_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         half_x_ff <= fbit_pkg::HALF_SIZE_RESET;
         half_y_ff <= fbit_pkg::HALF_SIZE_RESET;
         half_z_ff <= fbit_pkg::HALF_SIZE_RESET;
         fillet_ff <= fbit_pkg::FILLET_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            fbit_pkg::CSR_HALF_SIZE_X:   half_x_ff <= csr_wdata;
            fbit_pkg::CSR_HALF_SIZE_Y:   half_y_ff <= csr_wdata;
            fbit_pkg::CSR_HALF_SIZE_Z:   half_z_ff <= csr_wdata;
            fbit_pkg::CSR_FILLET_RADIUS: fillet_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Derived values are registered. Change config only while idle; not enforced.
   always_comb begin
      cfg_in.rx  = half_x_ff;
      cfg_in.ry  = half_y_ff;
      cfg_in.rz  = half_z_ff;
      cfg_in.sx  = half_x_ff - fillet_ff;
      cfg_in.sy  = half_y_ff - fillet_ff;
      cfg_in.sz  = half_z_ff - fillet_ff;
      cfg_in.f2  = fillet_ff * fillet_ff;
      cfg_in.err = (fillet_ff > half_x_ff) || (fillet_ff > half_y_ff) ||
                   (fillet_ff > half_z_ff);
   end

   always_ff @(posedge clock) begin
      cfg_ff <= cfg_in;
   end

   assign cfg = cfg_ff;

endmodule

// ----- src/filleted_box_inside_test.sv -----
// Top level of the filleted box inclusion test: four-stage point pipeline.
// Depends on fbit_pkg and fbit_cfg.
//
// Usage:
//   Request channel (req_*): one point px/py/pz, two's complement, 12 fraction
//   bits, accepted at a clock edge with req_valid high and req_stall low.
//   Response channel (rsp_*): inside_res, region and config_error for each
//   request, in order, taken at an edge with rsp_valid high and rsp_stall low.
//   CSR port (csr_*): half_size_x/y/z and fillet_radius, written at an edge
//   with csr_wr_en high; write only while no request is in flight.
// Pipeline: stage 1 absolute values, stage 2 extent compare and region select,
//   stage 3 squares (three 23x23 multipliers), stage 4 sum and compare into
//   the response register.
// Throughput: one request per cycle without rsp_stall; multipliers fully pipelined.
// Stall: each stage holds when its successor holds; bubbles are squeezed out,
//   so req_stall rises only when all four stages are full and rsp_stall is high.
// Reset: synchronous, clears all valid bits and loads the register defaults
//   (half sizes 1.0, fillet 0). Results in flight are dropped.
module filleted_box_inside_test #(
   parameter int COORD_WIDTH = fbit_pkg::COORD_WIDTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic signed [COORD_WIDTH-1:0]     req_px,
   input  logic signed [COORD_WIDTH-1:0]     req_py,
   input  logic signed [COORD_WIDTH-1:0]     req_pz,
   // response channel
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_inside_res,
   output logic [2:0]                        rsp_region,
   output logic                              rsp_config_error,
   // register write port
   input  logic                              csr_wr_en,
   input  logic [fbit_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [fbit_pkg::HALF_W-1:0]       csr_wdata
);

   localparam int HW    = fbit_pkg::HALF_W;
   localparam int CMP_W = (COORD_WIDTH > HW) ? COORD_WIDTH : HW;

   fbit_pkg::cfg_derived_type cfg;

   fbit_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // Magnitude of a coordinate; the most negative code maps to 2^(W-1).
   function automatic logic [COORD_WIDTH-1:0] mag(input logic [COORD_WIDTH-1:0] raw);
      mag = raw[COORD_WIDTH-1] ? (~raw + COORD_WIDTH'(1)) : raw;
   endfunction

   // ---------------- stage enables ----------------
   logic v1_ff, v2_ff, v3_ff, rsp_valid_ff;
   logic en1, en2, en3, en4;

   assign en4       = !rsp_valid_ff || !rsp_stall;
   assign en3       = !v3_ff || en4;
   assign en2       = !v2_ff || en3;
   assign en1       = !v1_ff || en2;
   assign req_stall = !en1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (en1) v1_ff        <= req_valid;
         if (en2) v2_ff        <= v1_ff;
         if (en3) v3_ff        <= v2_ff;
         if (en4) rsp_valid_ff <= v3_ff;
      end
   end

   // ---------------- stage 1: absolute values ----------------
   logic [COORD_WIDTH-1:0] ax1_ff, ay1_ff, az1_ff;

   always_ff @(posedge clock) begin
      if (en1) begin
         ax1_ff <= mag(req_px);
         ay1_ff <= mag(req_py);
         az1_ff <= mag(req_pz);
      end
   end

   // ---------------- stage 2: extent test and region ----------------
   logic [CMP_W-1:0]  ax_w, ay_w, az_w, dx_w, dy_w, dz_w;
   logic              beyond, lx, ly, lz, flat;
   fbit_pkg::region_type region2_in, region2_ff;
   logic              curve2_in, curve2_ff, inside2_in, inside2_ff, err2_ff;
   logic [HW-1:0]     dx2_in, dy2_in, dz2_in, dx2_ff, dy2_ff, dz2_ff;

   always_comb begin
      ax_w   = CMP_W'(ax1_ff);
      ay_w   = CMP_W'(ay1_ff);
      az_w   = CMP_W'(az1_ff);
      beyond = (ax_w >= CMP_W'(cfg.rx)) || (ay_w >= CMP_W'(cfg.ry)) ||
               (az_w >= CMP_W'(cfg.rz));
      lx     = ax_w <= CMP_W'(cfg.sx);
      ly     = ay_w <= CMP_W'(cfg.sy);
      lz     = az_w <= CMP_W'(cfg.sz);
      flat   = (ly && lz) || (lx && lz) || (lx && ly);
      // Offsets past the fillet start; positive and below the radius when used.
      dx_w   = ax_w - CMP_W'(cfg.sx);
      dy_w   = ay_w - CMP_W'(cfg.sy);
      dz_w   = az_w - CMP_W'(cfg.sz);
      dx2_in = lx ? '0 : dx_w[HW-1:0];
      dy2_in = ly ? '0 : dy_w[HW-1:0];
      dz2_in = lz ? '0 : dz_w[HW-1:0];

      curve2_in  = 1'b0;
      inside2_in = 1'b0;
      if (cfg.err || beyond) begin
         region2_in = fbit_pkg::REGION_OUTSIDE;
      end else if (flat) begin
         region2_in = fbit_pkg::REGION_FACE;
         inside2_in = 1'b1;
      end else begin
         curve2_in = 1'b1;
         if (lz)      region2_in = fbit_pkg::REGION_Z_EDGE;
         else if (ly) region2_in = fbit_pkg::REGION_Y_EDGE;
         else if (lx) region2_in = fbit_pkg::REGION_X_EDGE;
         else         region2_in = fbit_pkg::REGION_CORNER;
      end
   end

   always_ff @(posedge clock) begin
      if (en2) begin
         region2_ff <= region2_in;
         curve2_ff  <= curve2_in;
         inside2_ff <= inside2_in;
         err2_ff    <= cfg.err;
         dx2_ff     <= dx2_in;
         dy2_ff     <= dy2_in;
         dz2_ff     <= dz2_in;
      end
   end

   // ---------------- stage 3: squares ----------------
   logic [fbit_pkg::SQ_W-1:0] sqx3_in, sqy3_in, sqz3_in, sqx3_ff, sqy3_ff, sqz3_ff;
   fbit_pkg::region_type      region3_ff;
   logic                      curve3_ff, inside3_ff, err3_ff;

   assign sqx3_in = dx2_ff * dx2_ff;
   assign sqy3_in = dy2_ff * dy2_ff;
   assign sqz3_in = dz2_ff * dz2_ff;

   always_ff @(posedge clock) begin
      if (en3) begin
         sqx3_ff    <= sqx3_in;
         sqy3_ff    <= sqy3_in;
         sqz3_ff    <= sqz3_in;
         region3_ff <= region2_ff;
         curve3_ff  <= curve2_ff;
         inside3_ff <= inside2_ff;
         err3_ff    <= err2_ff;
      end
   end

   // ---------------- stage 4: distance compare, response register ----------------
   logic [fbit_pkg::SUM_W-1:0] d2;
   logic                       inside4_in;
   logic                       inside_ff, err_ff;
   fbit_pkg::region_type       region_ff;

   // Unused axes carry zero squares, so one three-term sum covers all regions.
   assign d2 = fbit_pkg::SUM_W'(sqx3_ff) + fbit_pkg::SUM_W'(sqy3_ff) +
               fbit_pkg::SUM_W'(sqz3_ff);
   assign inside4_in = curve3_ff ? (d2 < fbit_pkg::SUM_W'(cfg.f2)) : inside3_ff;

   always_ff @(posedge clock) begin
      if (en4) begin
         inside_ff <= inside4_in;
         region_ff <= region3_ff;
         err_ff    <= err3_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_inside_res   = inside_ff;
   assign rsp_region       = region_ff;
   assign rsp_config_error = err_ff;

   // ---------------- assertions ----------------
   a_err_forces_outside: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && err_ff) |-> (!inside_ff && region_ff == fbit_pkg::REGION_OUTSIDE))
      else $error("config error response not forced outside");

   a_outside_not_inside: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && region_ff == fbit_pkg::REGION_OUTSIDE) |-> !inside_ff)
      else $error("beyond-extent response reports inside");

   a_face_inside: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && region_ff == fbit_pkg::REGION_FACE) |-> inside_ff)
      else $error("flat-face response reports outside");

   a_stall_only_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (v1_ff && v2_ff && v3_ff && rsp_valid_ff && rsp_stall))
      else $error("request stalled with a free pipeline slot");

endmodule

// ----- verif/tb_filleted_box_inside_test.sv -----
`timescale 1ns / 1ps
// Self-checking bench for filleted_box_inside_test: directed and random points
// against an in-bench classifier. Depends on fbit_pkg and the block's RTL.
module tb_filleted_box_inside_test;

   localparam int CW        = fbit_pkg::COORD_WIDTH_DEFAULT;
   localparam int HW        = fbit_pkg::HALF_W;
   localparam int IW        = fbit_pkg::CSR_INDEX_W;
   localparam int HOLD_LEN  = 300;   // long receiver hold-off, in cycles
   localparam int BATCHES   = 9;
   localparam int BATCH_LEN = 205;

   // One request: a point.
   typedef struct {
      logic signed [CW-1:0] px;
      logic signed [CW-1:0] py;
      logic signed [CW-1:0] pz;
   } point_type;

   // One response: the verdict for a point.
   typedef struct packed {
      logic                 in_box;
      fbit_pkg::region_type region;
      logic                 err;
   } verdict_type;

   // How a coordinate is picked relative to the box.
   typedef enum int {
      SPAN_SLAB,     // within half extent minus fillet
      SPAN_BAND,     // within the fillet band
      SPAN_RIM,      // a few LSBs around the half extent
      SPAN_SPECIAL,  // zero, -1, most positive, most negative
      SPAN_WILD      // any 24-bit value
   } span_type;

   logic                 clock     = 1'b0;
   logic                 reset     = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic signed [CW-1:0] req_px    = '0;
   logic signed [CW-1:0] req_py    = '0;
   logic signed [CW-1:0] req_pz    = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic                 rsp_inside_res;
   logic [2:0]           rsp_region;
   logic                 rsp_config_error;
   logic                 csr_wr_en = 1'b0;
   logic [IW-1:0]        csr_index = '0;
   logic [HW-1:0]        csr_wdata = '0;

   // Bench copy of the register file.
   logic [HW-1:0] box_hx, box_hy, box_hz, box_fillet;

   point_type   point_q[$];     // requests waiting for the driver
   verdict_type verdict_q[$];   // verdicts owed by the block, oldest first

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int holds_asked   = 0;    // bumped by the sequencer, served by the receiver
   int mismatches    = 0;

   filleted_box_inside_test u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_px          (req_px),
      .req_py          (req_py),
      .req_pz          (req_pz),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_inside_res  (rsp_inside_res),
      .rsp_region      (rsp_region),
      .rsp_config_error(rsp_config_error),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Classifier: abs of each coordinate, extent reject, flat-face slabs, then
   // squared distance to the edge line or corner point against fillet^2.
   // All in 64-bit integers, so no width can wrap.
   function automatic verdict_type classify_point(input logic signed [CW-1:0] px,
                                                  input logic signed [CW-1:0] py,
                                                  input logic signed [CW-1:0] pz);
      longint ax, ay, az, rx, ry, rz, f, sx, sy, sz, dx, dy, dz, d2;
      verdict_type v;
      v = '{1'b0, fbit_pkg::REGION_OUTSIDE, 1'b0};
      rx = longint'(box_hx);
      ry = longint'(box_hy);
      rz = longint'(box_hz);
      f  = longint'(box_fillet);
      // bad fillet overrides everything
      if (f > rx || f > ry || f > rz) begin
         v.err = 1'b1;
         return v;
      end
      ax = longint'(px);
      ay = longint'(py);
      az = longint'(pz);
      // most negative value gets magnitude 2^23, still exact here
      if (ax < 0) ax = -ax;
      if (ay < 0) ay = -ay;
      if (az < 0) az = -az;
      if (ax >= rx || ay >= ry || az >= rz) return v;
      sx = rx - f;
      sy = ry - f;
      sz = rz - f;
      dx = ax - sx;
      dy = ay - sy;
      dz = az - sz;
      if ((ay <= sy && az <= sz) || (ax <= sx && az <= sz) || (ax <= sx && ay <= sy)) begin
         v.region = fbit_pkg::REGION_FACE;
         v.in_box = 1'b1;
         return v;
      end
      if (az <= sz) begin
         v.region = fbit_pkg::REGION_Z_EDGE;
         d2 = dx * dx + dy * dy;
      end else if (ay <= sy) begin
         v.region = fbit_pkg::REGION_Y_EDGE;
         d2 = dx * dx + dz * dz;
      end else if (ax <= sx) begin
         v.region = fbit_pkg::REGION_X_EDGE;
         d2 = dy * dy + dz * dz;
      end else begin
         v.region = fbit_pkg::REGION_CORNER;
         d2 = dx * dx + dy * dy + dz * dz;
      end
      // strictly less: a point on the fillet surface is outside
      v.in_box = (d2 < f * f);
      return v;
   endfunction

   // Register file mirror, updated at the same edge as the block's.
   always @(posedge clock) begin
      if (reset) begin
         box_hx     <= fbit_pkg::HALF_SIZE_RESET;
         box_hy     <= fbit_pkg::HALF_SIZE_RESET;
         box_hz     <= fbit_pkg::HALF_SIZE_RESET;
         box_fillet <= fbit_pkg::FILLET_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            fbit_pkg::CSR_HALF_SIZE_X:   box_hx     <= csr_wdata;
            fbit_pkg::CSR_HALF_SIZE_Y:   box_hy     <= csr_wdata;
            fbit_pkg::CSR_HALF_SIZE_Z:   box_hz     <= csr_wdata;
            fbit_pkg::CSR_FILLET_RADIUS: box_fillet <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Request driver. On acceptance the verdict is predicted from the point
   // just taken; a new point is loaded only when the slot is free.
   always @(posedge clock) begin
      point_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall)
            verdict_q.push_back(classify_point(req_px, req_py, req_pz));
         if (!req_valid || !req_stall) begin
            if (point_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               nxt = point_q.pop_front();
               req_valid <= 1'b1;
               req_px    <= nxt.px;
               req_py    <= nxt.py;
               req_pz    <= nxt.pz;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver stall. A requested hold-off keeps stall high until its HOLD_LEN
   // countdown runs out, so the pipe fills and pushes back on the request side.
   always @(posedge clock) begin
      int hold_left;
      int holds_served;
      if (reset) begin
         rsp_stall    <= 1'b0;
         hold_left    = 0;
         holds_served = 0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else if (holds_served != holds_asked) begin
         holds_served++;
         hold_left = HOLD_LEN - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // Response monitor: every accepted response against the oldest verdict.
   always @(posedge clock) begin
      verdict_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (verdict_q.size() == 0) begin
            $display("%0t: response with no request pending: inside %0b region %0d err %0b",
                     $time, rsp_inside_res, rsp_region, rsp_config_error);
            mismatches++;
         end else begin
            want = verdict_q.pop_front();
            if (rsp_inside_res !== want.in_box) begin
               $display("%0t: inside_res expected %0b actual %0b",
                        $time, want.in_box, rsp_inside_res);
               mismatches++;
            end
            if (rsp_region !== want.region) begin
               $display("%0t: region expected %0d actual %0d",
                        $time, want.region, rsp_region);
               mismatches++;
            end
            if (rsp_config_error !== want.err) begin
               $display("%0t: config_error expected %0b actual %0b",
                        $time, want.err, rsp_config_error);
               mismatches++;
            end
         end
      end
   end

   task automatic add_point(input int x, input int y, input int z);
      point_type p;
      p.px = CW'(x);
      p.py = CW'(y);
      p.pz = CW'(z);
      point_q.push_back(p);
   endtask

   // Wait until nothing is queued or in flight.
   task automatic wait_idle();
      while (point_q.size() != 0 || req_valid || verdict_q.size() != 0)
         @(negedge clock);
      repeat (6) @(negedge clock);
   endtask

   task automatic write_reg(input logic [IW-1:0] idx, input logic [HW-1:0] val);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Registers are only touched with the block drained.
   task automatic set_box(input logic [HW-1:0] hx, input logic [HW-1:0] hy,
                          input logic [HW-1:0] hz, input logic [HW-1:0] fil);
      wait_idle();
      write_reg(fbit_pkg::CSR_HALF_SIZE_X, hx);
      write_reg(fbit_pkg::CSR_HALF_SIZE_Y, hy);
      write_reg(fbit_pkg::CSR_HALF_SIZE_Z, hz);
      write_reg(fbit_pkg::CSR_FILLET_RADIUS, fil);
      @(negedge clock);
   endtask

   // One coordinate, placed relative to half extent and fillet of its axis.
   function automatic logic signed [CW-1:0] pick_coord(input span_type span,
                                                       input logic [HW-1:0] half,
                                                       input logic [HW-1:0] fil);
      int unsigned s, m;
      logic signed [CW-1:0] c;
      s = (half > fil) ? 32'(half - fil) : 0;
      case (span)
         SPAN_SLAB: m = $urandom_range(s, 0);
         SPAN_BAND: m = s + $urandom_range(fil, 0);
         SPAN_RIM:  m = (half < 2) ? $urandom_range(half + 1, 0)
                                   : half - 2 + $urandom_range(3, 0);
         SPAN_SPECIAL: begin
            case ($urandom_range(3))
               0:       c = '0;
               1:       c = '1;
               2:       c = {1'b0, {(CW-1){1'b1}}};
               default: c = {1'b1, {(CW-1){1'b0}}};
            endcase
            return c;
         end
         default: begin
            c = CW'($urandom);
            return c;
         end
      endcase
      // magnitude 2^23 only exists as the most negative value
      if (m >= (1 << (CW - 1))) return {1'b1, {(CW-1){1'b0}}};
      c = CW'(m);
      if ($urandom_range(1)) c = -c;
      return c;
   endfunction

   function automatic logic [HW-1:0] pick_half();
      case ($urandom_range(9))
         0:       return '0;
         1:       return '1;
         2, 3:    return HW'($urandom_range(1024, 16));
         4, 5, 6: return HW'($urandom_range(200000, 2048));
         default: return HW'($urandom);
      endcase
   endfunction

   // Stimulus sequencer.
   initial begin
      logic [HW-1:0] hs[3];
      logic [HW-1:0] mn, fil;
      span_type spans[3];
      logic signed [CW-1:0] c[3];
      logic [2:0] mask;
      int r;
      point_type p;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);
      send_idle_pct = 33;
      recv_idle_pct = 55;

      // Reset registers: half extents 1.0, no fillet, so inside means every |coord| < 1.0.
      add_point(0, 0, 0);
      add_point(4095, -4095, 4095);
      add_point(4096, 0, 0);
      add_point(0, -4096, 0);
      add_point(-1, -1, -1);
      add_point(8388607, 8388607, 8388607);
      add_point(-8388608, 0, 0);

      // Half 8192, fillet 2000: S = 6192. A 1200/1600 offset sits exactly on
      // the fillet (3-4-5 triangle), one LSB less is inside.
      set_box(8192, 8192, 8192, 2000);
      add_point(7000, 100, -100);
      add_point(7392, 7792, 0);
      add_point(-7392, 7791, 0);
      add_point(7392, 0, -7791);
      add_point(0, 7392, 7792);
      add_point(6800, -6800, 6800);
      add_point(7800, 7800, -7800);
      add_point(8191, 0, 0);

      // Fillet equal to every half extent: allowed, S = 0.
      set_box('1, '1, '1, '1);
      add_point(8388606, 0, 0);
      add_point(-8388608, -8388608, -8388608);
      add_point(1, 1, 1);
      add_point(8388607, 0, 0);
      add_point(5000000, 5000000, 5000000);

      // Fillet beyond one half extent: configuration error for any point.
      set_box(8192, '1, '1, '1);
      add_point(0, 0, 0);
      add_point(-8388608, 8388607, -1);

      // Zero-size box: nothing is inside.
      set_box(0, 0, 0, 0);
      add_point(0, 0, 0);

      for (int b = 0; b < BATCHES; b++) begin
         for (int a = 0; a < 3; a++)
            hs[a] = pick_half();
         mn = hs[0];
         if (hs[1] < mn) mn = hs[1];
         if (hs[2] < mn) mn = hs[2];
         case ($urandom_range(9))
            0:       fil = '0;
            1:       fil = mn;
            2:       fil = (mn == '1) ? mn : HW'($urandom_range(23'h7fffff, mn + 1));
            3:       fil = HW'($urandom);
            default: fil = HW'($urandom_range(mn, 0));
         endcase
         set_box(hs[0], hs[1], hs[2], fil);

         // sender/receiver idling: 33/55, then 55/33, then none
         if (b < 3) begin
            send_idle_pct = 33;
            recv_idle_pct = 55;
         end else if (b < 6) begin
            send_idle_pct = 55;
            recv_idle_pct = 33;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end

         for (int n = 0; n < BATCH_LEN; n++) begin
            r = $urandom_range(9);
            mask = 3'($urandom_range(7));
            for (int a = 0; a < 3; a++) begin
               // mostly shaped: each axis in its slab, out in the fillet band or at the
               // rim of the half extent, so faces, edges and corners all come up
               if (r < 8)
                  spans[a] = mask[a] ? (($urandom_range(4) == 0) ? SPAN_RIM : SPAN_BAND)
                                     : SPAN_SLAB;
               else if (r == 8)
                  spans[a] = SPAN_WILD;
               else
                  spans[a] = span_type'($urandom_range(4));
               c[a] = pick_coord(spans[a], hs[a], fil);
            end
            p.px = c[0];
            p.py = c[1];
            p.pz = c[2];
            point_q.push_back(p);
         end

         // long receiver hold-off while the sender keeps offering
         if (b == 0 || b == 6)
            holds_asked++;
      end

      wait_idle();
      if (mismatches == 0)
         $display("PASS filleted_box_inside_test");
      else
         $display("FAIL filleted_box_inside_test");
      $finish;
   end

   // Watchdog, far beyond the slowest legal run.
   initial begin
      #3000000;
      $display("FAIL filleted_box_inside_test");
      $finish;
   end

endmodule
